// ===== rtl/imm_pkg.sv =====
`timescale 1ns / 1ps

package imm_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_INNER = 64;
  localparam int MAX_COLS  = 64;

  localparam int IDX_W  = 6;
  localparam int SIZE_W = 7;
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  localparam int IN_BITS   = 2 * IDX_W + DATA_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 2 * IDX_W + DATA_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_RD   = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_INNER  = 2'd1,
    CFG_COLS_B = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic clear;     // start a new dot product
    logic data_vld;  // operand words from the stores are valid
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;      // a product is still on its way to the accumulator
  } mac_stat_t;

  // size register limited to its capacity
  function automatic logic [SIZE_W-1:0] limit_size(logic [SIZE_W-1:0] reg_v, int cap);
    logic [SIZE_W-1:0] res;
    if (int'(reg_v) < cap) res = reg_v;
    else res = SIZE_W'(cap);
    return res;
  endfunction

endpackage

// ===== rtl/imm_ram.sv =====
`timescale 1ns / 1ps

module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/imm_mac.sv =====
`timescale 1ns / 1ps

module imm_mac
  import imm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mac_ctrl_t         ctrl_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output mac_stat_t         stat_o,
  output logic [DATA_W-1:0] acc_o
);

  logic [DATA_W-1:0] prod_q;
  logic              prod_vld_q;
  logic [DATA_W-1:0] acc_q;

  // low word of the product is the same for signed and unsigned operands
  always_ff @(posedge clk_i) begin
    prod_q <= DATA_W'(a_i * b_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.data_vld;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  assign stat_o.busy = prod_vld_q;
  assign acc_o       = acc_q;

endmodule

// ===== rtl/integer_matrix_multiply.sv =====
`timescale 1ns / 1ps

// Integer matrix multiply. A and B are kept in two block RAMs, one word per
// element, loaded one element per input word (tuser selects write A, write B
// or read). A read of output element (row, col) walks the inner dimension
// with one multiply-accumulate per cycle, both operand RAMs read in the same
// cycle; the input side stays stalled until the result word is offered, and
// longer while an earlier result word has not been taken. The result sits
// in an output register, so the next word is taken while it waits. Sums
// wrap to 32 bits; accesses outside the configured sizes are dropped and
// reads of them give no word.
module integer_matrix_multiply
  import imm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SIZE_W-1:0]     cfg_data_i,
  // input words
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [5:0] row_index, [11:6] col_index, [43:12] element_value, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] operation
  input  logic [OP_W-1:0]       s_axis_tuser_i,
  // result words
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [5:0] result_row, [11:6] result_col, [43:12] product_value, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SIZE_W-1:0] rows_q, inner_q, cols_q;
  logic [SIZE_W-1:0] nr, nk, nc;

  logic [IDX_W-1:0]  in_row, in_col;
  logic [DATA_W-1:0] in_val;
  op_e               in_op;
  logic              in_acc;

  logic [IDX_W-1:0]  row_q, row_d, col_q, col_d;
  logic [SIZE_W-1:0] k_q, k_d;
  logic              rd_vld_q;

  logic              a_we, b_we;
  logic [A_AW-1:0]   a_waddr, a_raddr;
  logic [B_AW-1:0]   b_waddr, b_raddr;
  logic [DATA_W-1:0] a_rdata, b_rdata;

  mac_ctrl_t         mac_ctrl;
  mac_stat_t         mac_stat;
  logic [DATA_W-1:0] acc;

  logic              out_vld_q, out_vld_d, out_load;
  logic [IDX_W-1:0]  out_row_q, out_col_q;
  logic [DATA_W-1:0] out_val_q;

  assign in_row = s_axis_tdata_i[IDX_W-1:0];
  assign in_col = s_axis_tdata_i[2*IDX_W-1:IDX_W];
  assign in_val = s_axis_tdata_i[2*IDX_W+DATA_W-1:2*IDX_W];
  assign in_op  = op_e'(s_axis_tuser_i);

  assign nr = limit_size(rows_q, MAX_ROWS);
  assign nk = limit_size(inner_q, MAX_INNER);
  assign nc = limit_size(cols_q, MAX_COLS);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= SIZE_RESET;
      inner_q <= SIZE_RESET;
      cols_q  <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROWS_A: rows_q  <= cfg_data_i;
        CFG_INNER:  inner_q <= cfg_data_i;
        CFG_COLS_B: cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // store writes, row-major
  always_comb begin
    a_we = 1'b0;
    b_we = 1'b0;
    if (in_acc) begin
      case (in_op)
        OP_WR_A: a_we = (SIZE_W'(in_row) < nr) && (SIZE_W'(in_col) < nk);
        OP_WR_B: b_we = (SIZE_W'(in_row) < nk) && (SIZE_W'(in_col) < nc);
        default: ;
      endcase
    end
  end

  assign a_waddr = A_AW'(in_row) * A_AW'(MAX_INNER) + A_AW'(in_col);
  assign b_waddr = B_AW'(in_row) * B_AW'(MAX_COLS) + B_AW'(in_col);
  assign a_raddr = A_AW'(row_q) * A_AW'(MAX_INNER) + A_AW'(k_q);
  assign b_raddr = B_AW'(k_q) * B_AW'(MAX_COLS) + B_AW'(col_q);

  imm_ram #(.WIDTH(DATA_W), .DEPTH(A_DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (in_val),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  imm_ram #(.WIDTH(DATA_W), .DEPTH(B_DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (in_val),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    col_d         = col_q;
    k_d           = k_q;
    mac_ctrl      = '0;
    out_load      = 1'b0;
    out_vld_d     = out_vld_q && !m_axis_tready_i;
    mac_ctrl.data_vld = rd_vld_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_RD &&
            SIZE_W'(in_row) < nr && SIZE_W'(in_col) < nc) begin
          row_d          = in_row;
          col_d          = in_col;
          k_d            = '0;
          mac_ctrl.clear = 1'b1;
          state_d        = (nk == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        k_d = k_q + 1'b1;
        if (k_d == nk) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mac_stat.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= (state_q == ST_RUN);
      out_vld_q <= out_vld_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    if (out_load) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      out_val_q <= acc;
    end
  end

  imm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (a_rdata),
    .b_i    (b_rdata),
    .stat_o (mac_stat),
    .acc_o  (acc)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_val_q, out_col_q, out_row_q});

  // stores are only written while no dot product is being walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_we || b_we) |-> state_q == ST_IDLE)
    else $error("store write during a read walk");

  // the inner index never runs past the effective inner size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> k_q < nk)
    else $error("inner index out of range");

  // the result is taken only after the accumulator has settled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !mac_stat.busy && !rd_vld_q)
    else $error("result loaded while products in flight");

  // a finished result never overwrites an untaken one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_vld_q) |-> m_axis_tready_i)
    else $error("result word overwritten");

endmodule

// ===== tb/sv/tb_integer_matrix_multiply.sv =====
`timescale 1ns / 1ps

module tb_integer_matrix_multiply;
  import imm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 400;
  localparam int GAP_MAX      = 17;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] val;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] val;
  } product_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [SIZE_W-1:0]     cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [OP_W-1:0]       s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  integer_matrix_multiply u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // mirror of the block: stores and effective sizes
  logic [DATA_W-1:0] a_mirror [A_DEPTH];
  logic [DATA_W-1:0] b_mirror [B_DEPTH];
  int eff_rows  = MAX_ROWS;
  int eff_inner = MAX_INNER;
  int eff_cols  = MAX_COLS;

  // stimulus side bookkeeping: which entries have been queued for writing
  bit a_written [A_DEPTH];
  bit b_written [B_DEPTH];

  in_word_t pending_words[$];
  product_t product_q[$];
  in_word_t cur_word;

  int words_queued = 0;
  int words_taken  = 0;
  int useful_cnt   = 0;
  int errors       = 0;
  int send_wait    = 0;
  int recv_wait    = 0;
  bit send_idle    = 1'b1;
  bit recv_idle    = 1'b1;
  bit hold_request = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one accepted word to the mirror; a read in range yields a product
  task automatic mirror_word(input in_word_t w);
    logic [DATA_W-1:0] acc;
    product_t p;
    int k;
    case (w.op)
      OP_WR_A: begin
        if (w.row < eff_rows && w.col < eff_inner)
          a_mirror[int'(w.row) * MAX_INNER + int'(w.col)] = w.val;
      end
      OP_WR_B: begin
        if (w.row < eff_inner && w.col < eff_cols)
          b_mirror[int'(w.row) * MAX_COLS + int'(w.col)] = w.val;
      end
      OP_RD: begin
        if (w.row < eff_rows && w.col < eff_cols) begin
          acc = '0;
          for (k = 0; k < eff_inner; k++)
            acc = acc + a_mirror[int'(w.row) * MAX_INNER + k] *
                        b_mirror[k * MAX_COLS + int'(w.col)];
          p.row = w.row;
          p.col = w.col;
          p.val = acc;
          product_q.push_back(p);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_product(input logic [OUT_DATA_W-1:0] d);
    product_t got;
    product_t want;
    got.row = d[IDX_W-1:0];
    got.col = d[2*IDX_W-1:IDX_W];
    got.val = d[2*IDX_W +: DATA_W];
    if (product_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual row %0d col %0d value %0d",
               $time, got.row, got.col, $signed(got.val));
      errors++;
    end else begin
      want = product_q.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.val !== want.val) begin
        $display("%0t: mismatch, expected row %0d col %0d value %0d, actual row %0d col %0d value %0d",
                 $time, want.row, want.col, $signed(want.val),
                 got.row, got.col, $signed(got.val));
        errors++;
      end
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        mirror_word(cur_word);
        words_taken++;
        send_wait = send_idle ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        // stalled, hold the word
      end else if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= cur_word.op;
        s_axis_tdata_i  <= IN_DATA_W'({cur_word.val, cur_word.col, cur_word.row});
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_product(m_axis_tdata_o);
        recv_wait = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (hold_request) begin
        hold_request = 1'b0;
        recv_wait = LONG_HOLD;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic logic [DATA_W-1:0] next_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return DATA_W'($urandom_range(0, 16));
      4: return -DATA_W'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  // mostly in range, biased to a few low indexes so rows and columns get reused
  function automatic logic [IDX_W-1:0] pick_index(input int n);
    if (n == 0 || $urandom_range(0, 9) == 0)
      return IDX_W'($urandom_range(0, 63));
    if ($urandom_range(0, 1))
      return IDX_W'($urandom_range(0, (n < 4 ? n : 4) - 1));
    return IDX_W'($urandom_range(0, n - 1));
  endfunction

  task automatic queue_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
    in_word_t w;
    w.op  = op;
    w.row = r;
    w.col = c;
    w.val = v;
    pending_words.push_back(w);
    words_queued++;
    case (op)
      OP_WR_A: begin
        if (r < eff_rows && c < eff_inner) begin
          a_written[int'(r) * MAX_INNER + int'(c)] = 1'b1;
          useful_cnt++;
        end
      end
      OP_WR_B: begin
        if (r < eff_inner && c < eff_cols) begin
          b_written[int'(r) * MAX_COLS + int'(c)] = 1'b1;
          useful_cnt++;
        end
      end
      OP_RD: begin
        if (r < eff_rows && c < eff_cols)
          useful_cnt++;
      end
      default: ;
    endcase
  endtask

  // a read in range first fills whatever it would use that was never written
  task automatic request_product(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
    int k;
    if (r < eff_rows && c < eff_cols) begin
      for (k = 0; k < eff_inner; k++) begin
        if (!a_written[int'(r) * MAX_INNER + k])
          queue_word(OP_WR_A, r, IDX_W'(k), next_value());
        if (!b_written[k * MAX_COLS + int'(c)])
          queue_word(OP_WR_B, IDX_W'(k), c, next_value());
      end
    end
    queue_word(OP_RD, r, c, $urandom);
  endtask

  task automatic random_words(input int target);
    int tries;
    int pick;
    useful_cnt = 0;
    for (tries = 0; useful_cnt < target && tries < 4 * target; tries++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        queue_word(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), next_value());
      else if (pick <= 8)
        queue_word(OP_WR_A, pick_index(eff_rows), pick_index(eff_inner), next_value());
      else if (pick <= 14)
        queue_word(OP_WR_B, pick_index(eff_inner), pick_index(eff_cols), next_value());
      else
        request_product(pick_index(eff_rows), pick_index(eff_cols));
    end
  endtask

  // wait until every queued word is taken and every product has come back
  task automatic settle();
    while (words_taken != words_queued || product_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] inner,
                             input logic [SIZE_W-1:0] cols);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROWS_A;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INNER;
    cfg_data_i <= inner;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COLS_B;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    eff_rows  = (int'(rows) < MAX_ROWS) ? int'(rows) : MAX_ROWS;
    eff_inner = (int'(inner) < MAX_INNER) ? int'(inner) : MAX_INNER;
    eff_cols  = (int'(cols) < MAX_COLS) ? int'(cols) : MAX_COLS;
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] inner,
                           input logic [SIZE_W-1:0] cols, input int target,
                           input bit s_idle, input bit r_idle, input bit long_hold);
    settle();
    write_sizes(rows, inner, cols);
    send_idle = s_idle;
    recv_idle = r_idle;
    if (long_hold)
      hold_request = 1'b1;
    random_words(target);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // directed: 2x2 by 2x2 with extreme values, then ignored accesses
    write_sizes(7'd2, 7'd2, 7'd2);
    queue_word(OP_WR_A, 6'd0, 6'd0, 32'h7fff_ffff);
    queue_word(OP_WR_A, 6'd0, 6'd1, 32'h8000_0000);
    queue_word(OP_WR_A, 6'd1, 6'd0, 32'hffff_ffff);
    queue_word(OP_WR_A, 6'd1, 6'd1, 32'h0000_0001);
    queue_word(OP_WR_B, 6'd0, 6'd0, 32'h7fff_ffff);
    queue_word(OP_WR_B, 6'd0, 6'd1, 32'h0000_0002);
    queue_word(OP_WR_B, 6'd1, 6'd0, 32'h8000_0000);
    queue_word(OP_WR_B, 6'd1, 6'd1, 32'hffff_ffff);
    request_product(6'd0, 6'd0);
    request_product(6'd0, 6'd1);
    request_product(6'd1, 6'd0);
    request_product(6'd1, 6'd1);
    queue_word(OP_UNUSED, 6'd0, 6'd0, 32'h0000_0005);
    queue_word(OP_WR_A, 6'd2, 6'd0, 32'h1234_5678);
    queue_word(OP_WR_A, 6'd0, 6'd2, 32'h1234_5678);
    queue_word(OP_WR_A, 6'd63, 6'd63, 32'h1234_5678);
    queue_word(OP_WR_B, 6'd2, 6'd0, 32'h1234_5678);
    queue_word(OP_WR_B, 6'd0, 6'd63, 32'h1234_5678);
    request_product(6'd2, 6'd0);
    request_product(6'd0, 6'd2);
    request_product(6'd63, 6'd63);
    request_product(6'd1, 6'd1);

    // stores are kept across size changes, so later phases reuse earlier entries
    run_phase(7'd4, 7'd4, 7'd4, 170, 1'b1, 1'b1, 1'b0);
    run_phase(7'd1, 7'd64, 7'd1, 150, 1'b1, 1'b0, 1'b0);
    run_phase(7'd64, 7'd1, 7'd64, 140, 1'b0, 1'b1, 1'b0);
    run_phase(7'd0, 7'd3, 7'd3, 25, 1'b1, 1'b1, 1'b0);
    run_phase(7'd3, 7'd0, 7'd5, 40, 1'b1, 1'b1, 1'b0);
    run_phase(7'd127, 7'd2, 7'd127, 140, 1'b1, 1'b1, 1'b0);
    run_phase(7'd5, 7'd7, 7'd6, 170, 1'b0, 1'b0, 1'b1);
    run_phase(7'd64, 7'd64, 7'd64, 150, 1'b1, 1'b1, 1'b0);
    run_phase(7'd3, 7'd5, 7'd0, 30, 1'b0, 1'b1, 1'b0);
    run_phase(7'd8, 7'd6, 7'd8, 170, 1'b1, 1'b1, 1'b0);

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
